// File: hw/rtl/bems_pkg.sv
// ----------------------------------------------------------------------------
// bems_pkg
// Types and constants shared by the bilinear edge-mode sampler.
// ----------------------------------------------------------------------------
package bems_pkg;

	localparam int CW          = 9;   // texel index width
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;

	localparam logic       ACT_WRITE  = 1'b0;
	localparam logic       ACT_SAMPLE = 1'b1;

	localparam logic [2:0] EDGE_TRANSPARENT = 3'd0;
	localparam logic [2:0] EDGE_BLACK       = 3'd1;
	localparam logic [2:0] EDGE_CLAMP       = 3'd2;
	localparam logic [2:0] EDGE_MIRROR      = 3'd3;
	localparam logic [2:0] EDGE_WRAP        = 3'd4;

	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_EDGE_MODE      = 3'd2;
	localparam logic [2:0] REG_SRC_PREMULT    = 3'd3;
	localparam logic [2:0] REG_SRC_HAS_ALPHA  = 3'd4;

	localparam logic [11:0] ONE_OUT    = 12'd4080;
	localparam logic [20:0] RECIP_255  = 21'd1052688; // floor(2^28 / 255)
	localparam logic [19:0] ROUND_BIAS = 20'd127;

	typedef struct packed {
		logic               action;
		logic [7:0]         texel_x;
		logic [7:0]         texel_y;
		logic [7:0]         texel_red;
		logic [7:0]         texel_green;
		logic [7:0]         texel_blue;
		logic [7:0]         texel_alpha;
		logic signed [19:0] coord_x;
		logic signed [19:0] coord_y;
	} req_t;

	typedef struct packed {
		logic [11:0] sample_red;
		logic [11:0] sample_green;
		logic [11:0] sample_blue;
		logic [11:0] sample_alpha;
	} rsp_t;

	typedef struct packed {
		logic [8:0] image_width;
		logic [8:0] image_height;
		logic [2:0] edge_mode;
		logic       source_premultiplied;
		logic       source_has_alpha;
	} cfg_t;

	typedef struct packed {
		logic          on_img;
		logic [CW-1:0] i0;
		logic [CW-1:0] i1;
		logic [7:0]    wt;
	} axis_t;

	// one classified item between front and back
	typedef struct packed {
		logic          is_write;
		logic          is_sample;
		logic          wr_ok;
		logic          outside;
		logic          alpha_one;
		logic [CW-1:0] x0;
		logic [CW-1:0] x1;
		logic [CW-1:0] y0;
		logic [CW-1:0] y1;
		logic [7:0]    wx;
		logic [7:0]    wy;
		logic [31:0]   data;
	} op_t;

	// sample info carried alongside the back pipeline
	typedef struct packed {
		logic       outside;
		logic       alpha_one;
		logic [7:0] wx;
		logic [7:0] wy;
		logic       px0;
		logic       px1;
		logic       py0;
		logic       py1;
	} meta_t;

endpackage

// File: hw/rtl/bilinear_edge_mode_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_edge_mode_sampler
// A sample passes the queue, the bank read, stages s2 to s6 and the result
// register. Throughput one item per cycle while the receiver does not stall,
// set by the four parity banks that give all four taps in one read. Texel
// writes give no result. Reset clears control and configuration; texel store
// contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_edge_mode_sampler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bems_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bems_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [8:0]     cfg_data
);
	import bems_pkg::*;

	cfg_t cfg_q;
	op_t  front_op, head_op;
	logic q_full, q_not_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width          <= 9'd256;
			cfg_q.image_height         <= 9'd256;
			cfg_q.edge_mode            <= EDGE_TRANSPARENT;
			cfg_q.source_premultiplied <= 1'b0;
			cfg_q.source_has_alpha     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width          <= cfg_data;
				REG_IMAGE_HEIGHT:  cfg_q.image_height         <= cfg_data;
				REG_EDGE_MODE:     cfg_q.edge_mode            <= cfg_data[2:0];
				REG_SRC_PREMULT:   cfg_q.source_premultiplied <= cfg_data[0];
				REG_SRC_HAS_ALPHA: cfg_q.source_has_alpha     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign req_stall = q_full;

	bems_front u_front (
		.req(req),
		.cfg(cfg_q),
		.op (front_op)
	);

	bems_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (req_valid && !q_full),
		.push_op  (front_op),
		.pop      (q_pop),
		.head     (head_op),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	bems_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op       (head_op),
		.op_valid (q_not_empty),
		.pop      (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// File: hw/rtl/bems_ram.sv
// ----------------------------------------------------------------------------
// bems_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bems_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/bems_front.sv
// ----------------------------------------------------------------------------
// bems_front
// Classifies an item: texel write address check, or edge mode, texel-space
// scaling and clamping of a sample position into tap indexes and weights.
// ----------------------------------------------------------------------------
module bems_front (
	input  bems_pkg::req_t req,
	input  bems_pkg::cfg_t cfg,
	output bems_pkg::op_t  op
);
	import bems_pkg::*;

	function automatic logic [CW-1:0] limit_size(input logic [8:0] v, input int maxv);
		if (v == 9'd0) begin
			return 9'd1;
		end
		if (32'(v) > maxv) begin
			return 9'(maxv);
		end
		return v;
	endfunction

	function automatic axis_t tap_axis(input logic signed [19:0] p, input logic [CW-1:0] size,
		input logic [2:0] mode);
		axis_t             a;
		logic [16:0]       q;
		logic [25:0]       prod;
		logic signed [26:0] fs;
		logic [24:0]       hi;
		logic [24:0]       f;
		logic [9:0]        nxt;
		a.on_img = 1'b1;
		unique case (mode)
			EDGE_CLAMP: begin
				if (p < 0) q = 17'd0;
				else if (p > 20'sd65536) q = 17'h10000;
				else q = p[16:0];
			end
			EDGE_MIRROR: begin
				if (p[16:0] > 17'h10000) q = 17'(18'h20000 - {1'b0, p[16:0]});
				else q = p[16:0];
			end
			EDGE_WRAP: q = {1'b0, p[15:0]};
			default: begin
				a.on_img = (p >= 0) && (p <= 20'sd65536);
				q = p[16:0];
			end
		endcase
		prod = {9'b0, q} * {17'b0, size};
		fs   = $signed({1'b0, prod}) - 27'sd32768;
		hi   = {size - 9'd1, 16'b0};
		if (fs < 0) f = '0;
		else if (fs[25:0] > {1'b0, hi}) f = hi;
		else f = fs[24:0];
		a.i0 = f[24:16];
		a.wt = f[15:8];
		nxt  = {1'b0, a.i0} + 10'd1;
		a.i1 = (nxt < {1'b0, size}) ? nxt[8:0] : size - 9'd1;
		return a;
	endfunction

	logic [CW-1:0] size_x, size_y;
	axis_t         ax, ay;

	assign size_x = limit_size(cfg.image_width, MAX_WIDTH);
	assign size_y = limit_size(cfg.image_height, MAX_HEIGHT);
	assign ax     = tap_axis(req.coord_x, size_x, cfg.edge_mode);
	assign ay     = tap_axis(req.coord_y, size_y, cfg.edge_mode);

	always_comb begin
		op = '0;
		if (req.action == ACT_WRITE) begin
			op.is_write = 1'b1;
			op.wr_ok    = (32'(req.texel_x) < MAX_WIDTH) && (32'(req.texel_y) < MAX_HEIGHT);
			op.x0       = {1'b0, req.texel_x};
			op.x1       = {1'b0, req.texel_x};
			op.y0       = {1'b0, req.texel_y};
			op.y1       = {1'b0, req.texel_y};
			op.data     = {req.texel_alpha, req.texel_blue, req.texel_green, req.texel_red};
		end else begin
			op.is_sample = 1'b1;
			op.outside   = !(ax.on_img && ay.on_img);
			op.alpha_one = (cfg.edge_mode == EDGE_BLACK);
			op.x0        = ax.i0;
			op.x1        = ax.i1;
			op.y0        = ay.i0;
			op.y1        = ay.i1;
			op.wx        = ax.wt;
			op.wy        = ay.wt;
		end
	end

endmodule

// File: hw/rtl/bems_queue.sv
// ----------------------------------------------------------------------------
// bems_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bems_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bems_pkg::op_t push_op,
	input  logic          pop,
	output bems_pkg::op_t head,
	output logic          not_empty,
	output logic          full
);
	import bems_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	op_t           entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   count_q;

	assign head      = entry_q[rptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_op;
	end

endmodule

// File: hw/rtl/bems_back.sv
// ----------------------------------------------------------------------------
// bems_back
// Carries out items: texel writes into four parity banks, and for samples
// a four-tap read, premultiply, bilinear blend and rounding.
// ----------------------------------------------------------------------------
module bems_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bems_pkg::cfg_t cfg,
	input  bems_pkg::op_t  op,
	input  logic           op_valid,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bems_pkg::rsp_t rsp
);
	import bems_pkg::*;

	localparam int BW = (MAX_WIDTH + 1) / 2;
	localparam int BH = (MAX_HEIGHT + 1) / 2;
	localparam int BD = BW * BH;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;

	logic        en;
	logic [31:0] bank_rd [4];

	assign en  = !rsp_valid || !rsp_stall;
	assign pop = en && op_valid;

	// bank index is {y parity, x parity}
	for (genvar by = 0; by < 2; by++) begin : g_row
		for (genvar bx = 0; bx < 2; bx++) begin : g_col
			logic [CW-1:0] col, row;
			logic [AW-1:0] lin;
			logic          we;
			assign col = (op.x0[0] == 1'(bx)) ? op.x0 : op.x1;
			assign row = (op.y0[0] == 1'(by)) ? op.y0 : op.y1;
			assign lin = AW'(32'(row[CW-1:1]) * 32'(BW) + 32'(col[CW-1:1]));
			assign we  = pop && op.is_write && op.wr_ok &&
				(op.x0[0] == 1'(bx)) && (op.y0[0] == 1'(by));
			bems_ram #(.WIDTH(32), .DEPTH(BD)) u_bank (
				.clk  (clk),
				.we   (we),
				.waddr(lin),
				.wdata(op.data),
				.re   (en),
				.raddr(lin),
				.rdata(bank_rd[by*2+bx])
			);
		end
	end

	logic  v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	meta_t m1_s1, m2_s2, m3_s3, m4_s4, m5_s5, m6_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			v5_s5     <= 1'b0;
			v6_s6     <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			v1_s1     <= pop && op.is_sample;
			v2_s2     <= v1_s1;
			v3_s3     <= v2_s2;
			v4_s4     <= v3_s3;
			v5_s5     <= v4_s4;
			v6_s6     <= v5_s5;
			rsp_valid <= v6_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= '{outside: op.outside, alpha_one: op.alpha_one, wx: op.wx, wy: op.wy,
				px0: op.x0[0], px1: op.x1[0], py0: op.y0[0], py1: op.y1[0]};
			m2_s2 <= m1_s1;
			m3_s3 <= m2_s2;
			m4_s4 <= m3_s3;
			m5_s5 <= m4_s4;
			m6_s6 <= m5_s5;
		end
	end

	// taps: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
	logic [31:0] tap [4];
	always_comb begin
		tap[0] = bank_rd[{m1_s1.py0, m1_s1.px0}];
		tap[1] = bank_rd[{m1_s1.py0, m1_s1.px1}];
		tap[2] = bank_rd[{m1_s1.py1, m1_s1.px0}];
		tap[3] = bank_rd[{m1_s1.py1, m1_s1.px1}];
	end

	// straight colour: round(c*a*16/255) = floor((16*c*a + 127) / 255)
	logic [31:0] word_s2 [4];
	logic [19:0] v_s2    [4][3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				word_s2[t] <= tap[t];
				for (int c = 0; c < 3; c++) begin
					v_s2[t][c] <= {16'(tap[t][8*c +: 8] * tap[t][31:24]), 4'b0} + ROUND_BIAS;
				end
			end
		end
	end

	logic [40:0] recip_mul [4][3];
	always_comb begin
		for (int t = 0; t < 4; t++) begin
			for (int c = 0; c < 3; c++) begin
				recip_mul[t][c] = {21'b0, v_s2[t][c]} * {20'b0, RECIP_255};
			end
		end
	end

	logic [31:0] word_s3 [4];
	logic [19:0] v_s3    [4][3];
	logic [11:0] q0_s3   [4][3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				word_s3[t] <= word_s2[t];
				for (int c = 0; c < 3; c++) begin
					v_s3[t][c]  <= v_s2[t][c];
					q0_s3[t][c] <= recip_mul[t][c][39:28];
				end
			end
		end
	end

	// reciprocal can fall short by one: one compare and correct
	logic [11:0] px_next [4][4];
	always_comb begin
		for (int t = 0; t < 4; t++) begin
			for (int c = 0; c < 3; c++) begin
				logic [20:0] rem;
				logic [11:0] q;
				rem = {1'b0, v_s3[t][c]} - ({9'b0, q0_s3[t][c]} * 21'd255);
				q   = q0_s3[t][c] + 12'((rem >= 21'd255) ? 1 : 0);
				if (!cfg.source_has_alpha || cfg.source_premultiplied) begin
					px_next[t][c] = {word_s3[t][8*c +: 8], 4'b0};
				end else begin
					px_next[t][c] = q;
				end
			end
			px_next[t][3] = cfg.source_has_alpha ? {word_s3[t][31:24], 4'b0} : ONE_OUT;
		end
	end

	logic [11:0] px_s4 [4][4];
	always_ff @(posedge clk) begin
		if (en) px_s4 <= px_next;
	end

	logic [8:0] nwx, nwy;
	assign nwx = 9'd256 - {1'b0, m4_s4.wx};
	assign nwy = 9'd256 - {1'b0, m5_s5.wy};

	logic [19:0] top_s5 [4];
	logic [19:0] bot_s5 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				top_s5[c] <= 20'({8'b0, px_s4[0][c]} * {11'b0, nwx} +
					{8'b0, px_s4[1][c]} * {12'b0, m4_s4.wx});
				bot_s5[c] <= 20'({8'b0, px_s4[2][c]} * {11'b0, nwx} +
					{8'b0, px_s4[3][c]} * {12'b0, m4_s4.wx});
			end
		end
	end

	logic [27:0] sum_s6 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				sum_s6[c] <= 28'({8'b0, top_s5[c]} * {19'b0, nwy} +
					{8'b0, bot_s5[c]} * {20'b0, m5_s5.wy});
			end
		end
	end

	logic [11:0] res [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic [28:0] r;
			r = {1'b0, sum_s6[c]} + 29'd32768;
			res[c] = r[27:16];
		end
		if (m6_s6.outside) begin
			res[0] = '0;
			res[1] = '0;
			res[2] = '0;
			res[3] = m6_s6.alpha_one ? ONE_OUT : 12'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.sample_red   <= res[0];
			rsp.sample_green <= res[1];
			rsp.sample_blue  <= res[2];
			rsp.sample_alpha <= res[3];
		end
	end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear edge-mode sampler. Each phase sets the
// five registers, loads every texel that the image size can reach, then
// streams samples and rewrites under random sender bursts and receiver
// stalls. A scoreboard predicts each sample and checks results in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bems_pkg::*;

	localparam int LIMIT = 600000;
	localparam int STORE_W = 256;
	localparam int STORE_H = 256;

	class sample_scoreboard;
		bit [31:0]   texels [STORE_W*STORE_H];
		cfg_t        regs;
		rsp_t        expected_q [$];
		int          errors;

		function new();
			regs.image_width          = 9'd256;
			regs.image_height         = 9'd256;
			regs.edge_mode            = EDGE_TRANSPARENT;
			regs.source_premultiplied = 1'b0;
			regs.source_has_alpha     = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [8:0] val);
			case (idx)
				REG_IMAGE_WIDTH:   regs.image_width = val;
				REG_IMAGE_HEIGHT:  regs.image_height = val;
				REG_EDGE_MODE:     regs.edge_mode = val[2:0];
				REG_SRC_PREMULT:   regs.source_premultiplied = val[0];
				REG_SRC_HAS_ALPHA: regs.source_has_alpha = val[0];
				default: ;
			endcase
		endfunction

		function int eff_size(logic [8:0] v, int maxv);
			if (v == 0) return 1;
			return (v > maxv) ? maxv : int'(v);
		endfunction

		// fold one axis by edge mode; 0 when off-image in transparent/black or an unused mode
		function bit fold_axis(longint p, output longint q);
			case (regs.edge_mode)
				EDGE_CLAMP: begin
					q = (p < 0) ? 0 : ((p > 65536) ? 65536 : p);
					return 1;
				end
				EDGE_MIRROR: begin
					longint m;
					m = p & 'h1FFFF;
					q = (m > 65536) ? (131072 - m) : m;
					return 1;
				end
				EDGE_WRAP: begin
					q = p & 'hFFFF;
					return 1;
				end
				default: begin
					q = p;
					return (p >= 0 && p <= 65536);
				end
			endcase
		endfunction

		function void tap_axis(longint p, int size, output int i0, output int i1,
				output longint wt);
			longint f;
			f = p * size - 32768;
			if (f < 0) f = 0;
			if (f > longint'(size - 1) * 65536) f = longint'(size - 1) * 65536;
			i0 = int'(f >>> 16);
			wt = (f >>> 8) & 255;
			i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
		endfunction

		function void texel_rgba(int x, int y, output longint px [4]);
			bit [31:0] w;
			longint ch [4];
			w = texels[y*STORE_W + x];
			for (int c = 0; c < 4; c++) ch[c] = w[8*c +: 8];
			for (int c = 0; c < 4; c++) px[c] = (ch[c] * 4080 + 127) / 255;
			if (!regs.source_has_alpha)
				px[3] = 4080;
			else if (!regs.source_premultiplied)
				for (int c = 0; c < 3; c++)
					px[c] = (ch[c] * ch[3] * 4080 + 32512) / 65025;
		endfunction

		function void note_input(req_t r);
			longint qx, qy, wx, wy, top, bot, s;
			longint p00 [4], p10 [4], p01 [4], p11 [4], v [4];
			bit inx, iny;
			int x0, x1, y0, y1, w, h;
			rsp_t e;
			if (r.action == ACT_WRITE) begin
				texels[int'(r.texel_y)*STORE_W + int'(r.texel_x)] =
					{r.texel_alpha, r.texel_blue, r.texel_green, r.texel_red};
				return;
			end
			inx = fold_axis(longint'($signed(r.coord_x)), qx);
			iny = fold_axis(longint'($signed(r.coord_y)), qy);
			if (!(inx && iny)) begin
				v[0] = 0; v[1] = 0; v[2] = 0;
				v[3] = (regs.edge_mode == EDGE_BLACK) ? 4080 : 0;
			end else begin
				w = eff_size(regs.image_width, STORE_W);
				h = eff_size(regs.image_height, STORE_H);
				tap_axis(qx, w, x0, x1, wx);
				tap_axis(qy, h, y0, y1, wy);
				texel_rgba(x0, y0, p00);
				texel_rgba(x1, y0, p10);
				texel_rgba(x0, y1, p01);
				texel_rgba(x1, y1, p11);
				for (int c = 0; c < 4; c++) begin
					top = p00[c] * (256 - wx) + p10[c] * wx;
					bot = p01[c] * (256 - wx) + p11[c] * wx;
					s = top * (256 - wy) + bot * wy;
					v[c] = (s + 32768) >>> 16;
				end
			end
			e.sample_red   = v[0][11:0];
			e.sample_green = v[1][11:0];
			e.sample_blue  = v[2][11:0];
			e.sample_alpha = v[3][11:0];
			expected_q = {expected_q, e};
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected sample result %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.sample_red !== e.sample_red) begin
				$error("sample_red exp %0d got %0d", e.sample_red, got.sample_red);
				errors++;
			end
			if (got.sample_green !== e.sample_green) begin
				$error("sample_green exp %0d got %0d", e.sample_green, got.sample_green);
				errors++;
			end
			if (got.sample_blue !== e.sample_blue) begin
				$error("sample_blue exp %0d got %0d", e.sample_blue, got.sample_blue);
				errors++;
			end
			if (got.sample_alpha !== e.sample_alpha) begin
				$error("sample_alpha exp %0d got %0d", e.sample_alpha, got.sample_alpha);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	sample_scoreboard sb;
	bit written [STORE_W*STORE_H];
	int cycles;
	int burst_left;
	int stall_left;
	int stall_mode;

	bilinear_edge_mode_sampler DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		sb = new();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL bilinear_edge_mode_sampler");
			$finish;
		end
	end

	// receiver: stall pattern switches between randomly chosen modes
	initial begin
		rsp_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(10, 80);
			end
			stall_left--;
			case (stall_mode)
				0: rsp_stall = 1'b0;
				1: rsp_stall = ($urandom % 4) == 0;
				2: rsp_stall = ($urandom % 2) == 0;
				default: rsp_stall = ($urandom % 8) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
	end

	function automatic req_t rand_item();
		logic [127:0] raw;
		req_t r;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		return r;
	endfunction

	task automatic send_item(req_t r);
		if (burst_left == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_input(r);
		@(negedge clk);
	endtask

	task automatic send_write(int x, int y);
		req_t r;
		r = rand_item();
		r.action = ACT_WRITE;
		r.texel_x = x[7:0];
		r.texel_y = y[7:0];
		written[y*STORE_W + x] = 1'b1;
		send_item(r);
	endtask

	task automatic send_sample(logic [19:0] cx, logic [19:0] cy);
		req_t r;
		r = rand_item();
		r.action = ACT_SAMPLE;
		r.coord_x = cx;
		r.coord_y = cy;
		send_item(r);
	endtask

	task automatic wait_idle();
		req_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// set all registers and load every texel the sampler can reach that is not yet written
	task automatic setup_phase(logic [8:0] w, logic [8:0] h, logic [2:0] mode,
			logic pm, logic ha);
		int ew, eh;
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_EDGE_MODE, {6'd0, mode});
		write_reg(REG_SRC_PREMULT, {8'd0, pm});
		write_reg(REG_SRC_HAS_ALPHA, {8'd0, ha});
		ew = sb.eff_size(w, STORE_W);
		eh = sb.eff_size(h, STORE_H);
		for (int y = 0; y < eh; y++)
			for (int x = 0; x < ew; x++)
				if (!written[y*STORE_W + x]) send_write(x, y);
	endtask

	function automatic logic [19:0] rand_coord();
		int k;
		k = $urandom_range(0, 3);
		if (k == 0) return 20'($urandom);
		if (k == 1) return 20'($urandom_range(0, 65536));
		return 20'($signed($urandom_range(0, 81920)) - 8192);
	endfunction

	initial begin
		logic [19:0] pts [6];
		logic [8:0] w, h;
		int ew, eh, n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: edges and both extremes of the coordinate, every selector
		pts[0] = 20'sd0;      pts[1] = 20'sd65536;  pts[2] = -20'sd1;
		pts[3] = 20'sd65537;  pts[4] = 20'h7FFFF;   pts[5] = 20'h80000;
		setup_phase(9'd256, 9'd1, EDGE_TRANSPARENT, 1'b0, 1'b1);
		for (int m = 0; m < 8; m++) begin
			if (m != 0) begin
				wait_idle();
				write_reg(REG_EDGE_MODE, 9'(m));
			end
			for (int i = 0; i < 3; i++)
				send_sample(pts[(i + m) % 6], pts[(i * 2 + m) % 6]);
		end
		setup_phase(9'd1, 9'd256, EDGE_CLAMP, 1'b1, 1'b1);
		send_sample(20'sd32768, 20'sd65535);
		send_sample(20'sd65536, 20'sd0);
		setup_phase(9'd511, 9'd0, EDGE_WRAP, 1'b0, 1'b0);
		send_sample(20'sd65535, 20'sd32768);
		send_sample(20'h80000, 20'h7FFFF);

		// random phases, mostly small images
		for (int ph = 0; ph < 18; ph++) begin
			case ($urandom_range(0, 7))
				0: begin w = 9'($urandom_range(257, 511)); h = 9'($urandom_range(0, 1)); end
				1: begin w = 9'($urandom_range(0, 1)); h = 9'($urandom_range(256, 511)); end
				default: begin
					w = 9'($urandom_range(0, 12));
					h = 9'($urandom_range(0, 12));
				end
			endcase
			setup_phase(w, h, 3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom));
			ew = sb.eff_size(w, STORE_W);
			eh = sb.eff_size(h, STORE_H);
			n = $urandom_range(20, 45);
			for (int i = 0; i < n; i++) begin
				if ($urandom % 5 == 0)
					send_write($urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
				send_sample(rand_coord(), rand_coord());
			end
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASS bilinear_edge_mode_sampler");
		else
			$display("FAIL bilinear_edge_mode_sampler");
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/bems_pkg.sv
hw/rtl/bems_ram.sv
hw/rtl/bems_front.sv
hw/rtl/bems_queue.sv
hw/rtl/bems_back.sv
hw/rtl/bilinear_edge_mode_sampler.sv
dv/testbench.sv
